// ----- rtl/mjt_pkg.sv -----
package mjt_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC = 16;
  localparam int AXES = 3;
  localparam int NSTG = 10;
  localparam int CFG_ADDR_W = 3;

  // Up to the end of the trajectory, normalized time and its powers stay within [0, 1.0] in Q16.16.
  localparam int S_W = FRAC + 1;

  // Shape sums: position, velocity and acceleration profiles in Q16.16.
  localparam int R_W = 23;
  localparam int D_W = 25;
  localparam int A_W = 27;

  localparam int ONE_Q16 = 1 << FRAC;
  localparam logic [2*DATA_W-1:0] END_LIMIT = 64'h0000_0001_0000_0000;

  localparam int K_R3 = 10;
  localparam int K_R4 = 15;
  localparam int K_R5 = 6;
  localparam int K_D2 = 30;
  localparam int K_D3 = 60;
  localparam int K_D4 = 30;
  localparam int K_A1 = 60;
  localparam int K_A2 = 180;
  localparam int K_A3 = 120;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_DELTA_X,
    REG_DELTA_Y,
    REG_DELTA_Z,
    REG_INV_DUR,
    REG_INV_DUR_SQ
  } cfg_reg_t;

  typedef struct packed {
    logic [S_W-1:0] s1;
    logic [S_W-1:0] s2;
    logic [S_W-1:0] s3;
    logic [S_W-1:0] s4;
    logic [S_W-1:0] s5;
  } pow_t;

  typedef struct packed {
    logic mul1;
    logic trunc1;
    logic mul2;
    logic fin;
  } axis_en_t;

  function automatic logic [S_W-1:0] pow_mul(input logic [S_W-1:0] a,
                                             input logic [S_W-1:0] b);
    logic [2*S_W-1:0] m;
    m = (2*S_W)'(a) * (2*S_W)'(b);
    return m[FRAC +: S_W];
  endfunction

  function automatic logic signed [31:0] sx(input logic [S_W-1:0] v);
    return signed'(32'(v));
  endfunction

  function automatic logic signed [63:0] trunc_q16(input logic signed [63:0] p);
    return (p + (p[63] ? 64'sd65535 : 64'sd0)) >>> FRAC;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/mjt_if.sv -----
interface mjt_in_if;
  logic valid;
  logic ready;
  logic [mjt_pkg::DATA_W-1:0] sample_time;

  modport source(output valid, sample_time, input ready);
  modport sink(input valid, sample_time, output ready);
endinterface

interface mjt_out_if;
  logic valid;
  logic ready;
  logic signed [mjt_pkg::DATA_W-1:0] pos_x;
  logic signed [mjt_pkg::DATA_W-1:0] pos_y;
  logic signed [mjt_pkg::DATA_W-1:0] pos_z;
  logic signed [mjt_pkg::DATA_W-1:0] vel_x;
  logic signed [mjt_pkg::DATA_W-1:0] vel_y;
  logic signed [mjt_pkg::DATA_W-1:0] vel_z;
  logic signed [mjt_pkg::DATA_W-1:0] acc_x;
  logic signed [mjt_pkg::DATA_W-1:0] acc_y;
  logic signed [mjt_pkg::DATA_W-1:0] acc_z;
  logic finished;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 acc_x, acc_y, acc_z, finished, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               acc_x, acc_y, acc_z, finished, output ready);
endinterface

interface mjt_cfg_if;
  logic valid;
  logic ready;
  logic [mjt_pkg::CFG_ADDR_W-1:0] addr;
  logic [mjt_pkg::DATA_W-1:0] data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ----- rtl/mjt_axis.sv -----
module mjt_axis (
  input  logic                            clk,
  input  mjt_pkg::axis_en_t               en,
  input  logic signed [mjt_pkg::DATA_W-1:0] start_i,
  input  logic signed [mjt_pkg::DATA_W-1:0] delta_i,
  input  logic [mjt_pkg::DATA_W-1:0]      inv_dur_i,
  input  logic [mjt_pkg::DATA_W-1:0]      inv_dur_sq_i,
  input  logic signed [mjt_pkg::R_W-1:0]  r_i,
  input  logic signed [mjt_pkg::D_W-1:0]  d_i,
  input  logic signed [mjt_pkg::A_W-1:0]  a_i,
  output logic signed [mjt_pkg::DATA_W-1:0] pos_o,
  output logic signed [mjt_pkg::DATA_W-1:0] vel_o,
  output logic signed [mjt_pkg::DATA_W-1:0] acc_o
);
  import mjt_pkg::*;

  localparam int PP_W = DATA_W + R_W;
  localparam int PV_W = DATA_W + D_W;
  localparam int PA_W = DATA_W + A_W;
  localparam int VX_W = PV_W - FRAC;
  localparam int AX_W = PA_W - FRAC;
  localparam int HALF = DATA_W / 2;
  localparam int VP_W = VX_W + HALF + 1;
  localparam int AP_W = AX_W + HALF + 1;

  logic signed [PP_W-1:0] pp_r, pp_nxt;
  logic signed [PV_W-1:0] pv_r, pv_nxt;
  logic signed [PA_W-1:0] pa_r, pa_nxt;

  logic signed [DATA_W-1:0] pos8_r, pos8_nxt;
  logic signed [VX_W-1:0] vx_r, vx_nxt;
  logic signed [AX_W-1:0] ax_r, ax_nxt;

  logic signed [DATA_W-1:0] pos9_r;
  logic signed [VP_W-1:0] vh_r, vh_nxt, vl_r, vl_nxt;
  logic signed [AP_W-1:0] ah_r, ah_nxt, al_r, al_nxt;
  logic vneg_r, aneg_r;

  logic signed [DATA_W-1:0] pos_r, vel_r, vel_nxt, acc_r, acc_nxt;

  logic signed [HALF:0] ivh, ivl, isqh, isql;

  always_comb begin
    pp_nxt = PP_W'(delta_i) * PP_W'(r_i);
    pv_nxt = PV_W'(delta_i) * PV_W'(d_i);
    pa_nxt = PA_W'(delta_i) * PA_W'(a_i);

    pos8_nxt = sat32(64'(start_i) + trunc_q16(64'(pp_r)));
    vx_nxt = VX_W'(trunc_q16(64'(pv_r)));
    ax_nxt = AX_W'(trunc_q16(64'(pa_r)));

    ivh  = signed'({1'b0, inv_dur_i[DATA_W-1:HALF]});
    ivl  = signed'({1'b0, inv_dur_i[HALF-1:0]});
    isqh = signed'({1'b0, inv_dur_sq_i[DATA_W-1:HALF]});
    isql = signed'({1'b0, inv_dur_sq_i[HALF-1:0]});
    vh_nxt = VP_W'(vx_r) * VP_W'(ivh);
    vl_nxt = VP_W'(vx_r) * VP_W'(ivl);
    ah_nxt = AP_W'(ax_r) * AP_W'(isqh);
    al_nxt = AP_W'(ax_r) * AP_W'(isql);

    // The rounding bias follows the sign of the whole product; the second
    // factor is never negative.
    vel_nxt = sat32(64'(vh_r) + ((64'(vl_r) + (vneg_r ? 64'sd65535 : 64'sd0)) >>> FRAC));
    acc_nxt = sat32(64'(ah_r) + ((64'(al_r) + (aneg_r ? 64'sd65535 : 64'sd0)) >>> FRAC));
  end

  always_ff @(posedge clk) begin
    if (en.mul1) begin
      pp_r <= pp_nxt;
      pv_r <= pv_nxt;
      pa_r <= pa_nxt;
    end
    if (en.trunc1) begin
      pos8_r <= pos8_nxt;
      vx_r <= vx_nxt;
      ax_r <= ax_nxt;
    end
    if (en.mul2) begin
      pos9_r <= pos8_r;
      vh_r <= vh_nxt;
      vl_r <= vl_nxt;
      ah_r <= ah_nxt;
      al_r <= al_nxt;
      vneg_r <= vx_r[VX_W-1];
      aneg_r <= ax_r[AX_W-1];
    end
    if (en.fin) begin
      pos_r <= pos9_r;
      vel_r <= vel_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign pos_o = pos_r;
  assign vel_o = vel_r;
  assign acc_o = acc_r;

endmodule

// ----- rtl/min_jerk_trajectory_eval_unit.sv -----
// Throughput: one item per cycle unless the output stalls; ten register stages, each
// holding at most one 32 by 32 multiply or one wide add, compare and saturate.
// Each stage stalls only when it is full and the stage after it cannot take its item.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers: start and delta to zero, both reciprocals to 1.0.
module min_jerk_trajectory_eval_unit (
  input logic       clk,
  input logic       rst_n,
  mjt_in_if.sink    in_ch,
  mjt_out_if.source out_ch,
  mjt_cfg_if.sink   cfg_ch
);
  import mjt_pkg::*;

  logic signed [DATA_W-1:0] start_r [AXES];
  logic signed [DATA_W-1:0] delta_r [AXES];
  logic [DATA_W-1:0] inv_dur_r, inv_dur_sq_r;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;
  logic [NSTG-1:1] done_r;

  logic [2*DATA_W-1:0] p_r, p_nxt;
  logic done_nxt;
  pow_t pw_r [1:4];
  pow_t pw_nxt [1:4];

  logic signed [31:0] r_sum, d_sum, a_sum;
  logic signed [R_W-1:0] r_r, r_nxt;
  logic signed [D_W-1:0] d_r, d_nxt;
  logic signed [A_W-1:0] a_r, a_nxt;

  axis_en_t ax_en;
  logic signed [DATA_W-1:0] pos [AXES];
  logic signed [DATA_W-1:0] vel [AXES];
  logic signed [DATA_W-1:0] acc [AXES];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        start_r[i] <= '0;
        delta_r[i] <= '0;
      end
      inv_dur_r <= DATA_W'(ONE_Q16);
      inv_dur_sq_r <= DATA_W'(ONE_Q16);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.addr))
        REG_START_X:    start_r[0] <= cfg_ch.data;
        REG_START_Y:    start_r[1] <= cfg_ch.data;
        REG_START_Z:    start_r[2] <= cfg_ch.data;
        REG_DELTA_X:    delta_r[0] <= cfg_ch.data;
        REG_DELTA_Y:    delta_r[1] <= cfg_ch.data;
        REG_DELTA_Z:    delta_r[2] <= cfg_ch.data;
        REG_INV_DUR:    inv_dur_r <= cfg_ch.data;
        REG_INV_DUR_SQ: inv_dur_sq_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    p_nxt = (2*DATA_W)'(in_ch.sample_time) * (2*DATA_W)'(inv_dur_r);
    done_nxt = p_r > END_LIMIT;

    pw_nxt[1] = '0;
    pw_nxt[1].s1 = p_r[FRAC +: S_W];
    pw_nxt[1].s2 = pow_mul(p_r[FRAC +: S_W], p_r[FRAC +: S_W]);
    pw_nxt[2] = pw_r[1];
    pw_nxt[2].s3 = pow_mul(pw_r[1].s2, pw_r[1].s1);
    pw_nxt[3] = pw_r[2];
    pw_nxt[3].s4 = pow_mul(pw_r[2].s3, pw_r[2].s1);
    pw_nxt[4] = pw_r[3];
    pw_nxt[4].s5 = pow_mul(pw_r[3].s4, pw_r[3].s1);

    r_sum = K_R3 * sx(pw_r[4].s3) - K_R4 * sx(pw_r[4].s4) + K_R5 * sx(pw_r[4].s5);
    d_sum = K_D2 * sx(pw_r[4].s2) - K_D3 * sx(pw_r[4].s3) + K_D4 * sx(pw_r[4].s4);
    a_sum = K_A1 * sx(pw_r[4].s1) - K_A2 * sx(pw_r[4].s2) + K_A3 * sx(pw_r[4].s3);

    // Past the end the position shape is exactly 1.0 and the others vanish.
    if (done_r[4]) begin
      r_nxt = R_W'(ONE_Q16);
      d_nxt = '0;
      a_nxt = '0;
    end else begin
      r_nxt = R_W'(r_sum);
      d_nxt = D_W'(d_sum);
      a_nxt = A_W'(a_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r <= p_nxt;
    end
    if (en[1]) begin
      pw_r[1] <= pw_nxt[1];
      done_r[1] <= done_nxt;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        pw_r[k] <= pw_nxt[k];
      end
    end
    for (int k = 2; k < NSTG; k++) begin
      if (en[k]) begin
        done_r[k] <= done_r[k-1];
      end
    end
    if (en[5]) begin
      r_r <= r_nxt;
      d_r <= d_nxt;
      a_r <= a_nxt;
    end
  end

  assign ax_en.mul1 = en[6];
  assign ax_en.trunc1 = en[7];
  assign ax_en.mul2 = en[8];
  assign ax_en.fin = en[9];

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    mjt_axis u_axis (
      .clk          (clk),
      .en           (ax_en),
      .start_i      (start_r[g]),
      .delta_i      (delta_r[g]),
      .inv_dur_i    (inv_dur_r),
      .inv_dur_sq_i (inv_dur_sq_r),
      .r_i          (r_r),
      .d_i          (d_r),
      .a_i          (a_r),
      .pos_o        (pos[g]),
      .vel_o        (vel[g]),
      .acc_o        (acc[g])
    );
  end

  assign out_ch.valid = v_r[NSTG-1];
  assign out_ch.pos_x = pos[0];
  assign out_ch.pos_y = pos[1];
  assign out_ch.pos_z = pos[2];
  assign out_ch.vel_x = vel[0];
  assign out_ch.vel_y = vel[1];
  assign out_ch.vel_z = vel[2];
  assign out_ch.acc_x = acc[0];
  assign out_ch.acc_y = acc[1];
  assign out_ch.acc_z = acc[2];
  assign out_ch.finished = done_r[NSTG-1];

endmodule

// ----- rtl/mjt_chk.sv -----
module mjt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [mjt_pkg::DATA_W-1:0] pos_x,
  input logic signed [mjt_pkg::DATA_W-1:0] vel_x,
  input logic signed [mjt_pkg::DATA_W-1:0] vel_y,
  input logic signed [mjt_pkg::DATA_W-1:0] vel_z,
  input logic signed [mjt_pkg::DATA_W-1:0] acc_x,
  input logic signed [mjt_pkg::DATA_W-1:0] acc_y,
  input logic signed [mjt_pkg::DATA_W-1:0] acc_z,
  input logic                             finished,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x))
    else $error("stalled result dropped or changed");

  a_end_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> vel_x == 0 && vel_y == 0 && vel_z == 0 &&
                              acc_x == 0 && acc_y == 0 && acc_z == 0)
    else $error("motion after the end of the trajectory");

  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although the output drains");

  a_cfg_always: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind min_jerk_trajectory_eval_unit mjt_chk u_mjt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pos_x     (out_ch.pos_x),
  .vel_x     (out_ch.vel_x),
  .vel_y     (out_ch.vel_y),
  .vel_z     (out_ch.vel_z),
  .acc_x     (out_ch.acc_x),
  .acc_y     (out_ch.acc_y),
  .acc_z     (out_ch.acc_z),
  .finished  (out_ch.finished),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);

// ----- test/tb_min_jerk_trajectory_eval_unit.sv -----
`timescale 1ns / 100ps

module tb_min_jerk_trajectory_eval_unit;
  import mjt_pkg::*;

  localparam int NUM_REGS = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PROFILES = 10;
  localparam int SAMPLES_PER_PROFILE = 100;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               finished;
  } traj_point_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  mjt_in_if  in_bus ();
  mjt_out_if out_bus ();
  mjt_cfg_if cfg_bus ();

  min_jerk_trajectory_eval_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  logic [31:0] profile_regs [NUM_REGS];
  logic [31:0] profile_plan [NUM_REGS];
  traj_point_t expected_points [$];
  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Q16.16 product of two signed values, truncated toward zero.
  function automatic longint q16_mul(longint x, longint y);
    logic signed [127:0] wx, wy, prod, mag;
    wx = x;
    wy = y;
    prod = wx * wy;
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> FRAC;
    return (prod < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic traj_point_t predict_point(logic [31:0] t);
    traj_point_t pt;
    logic [63:0] phase;
    longint s, s2, s3, s4, s5, rsh, dsh, ash;
    longint org [3];
    longint dlt [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] acc [3];
    bit done;
    int i;
    phase = 64'(t) * 64'(profile_regs[REG_INV_DUR]);
    done = phase > 64'h1_0000_0000;
    rsh = ONE_Q16;
    dsh = 0;
    ash = 0;
    if (!done) begin
      s = longint'(phase >> FRAC);
      s2 = (s * s) >>> FRAC;
      s3 = (s2 * s) >>> FRAC;
      s4 = (s3 * s) >>> FRAC;
      s5 = (s4 * s) >>> FRAC;
      rsh = 10 * s3 - 15 * s4 + 6 * s5;
      dsh = 30 * s2 - 60 * s3 + 30 * s4;
      ash = 60 * s - 180 * s2 + 120 * s3;
    end
    for (i = 0; i < 3; i++) begin
      org[i] = signed'(profile_regs[REG_START_X + i]);
      dlt[i] = signed'(profile_regs[REG_DELTA_X + i]);
      pos[i] = clamp32(org[i] + q16_mul(dlt[i], rsh));
      vel[i] = done ? 32'sd0 : clamp32(q16_mul(q16_mul(dlt[i], dsh),
                                               longint'(profile_regs[REG_INV_DUR])));
      acc[i] = done ? 32'sd0 : clamp32(q16_mul(q16_mul(dlt[i], ash),
                                               longint'(profile_regs[REG_INV_DUR_SQ])));
    end
    pt.pos_x = pos[0];
    pt.pos_y = pos[1];
    pt.pos_z = pos[2];
    pt.vel_x = vel[0];
    pt.vel_y = vel[1];
    pt.vel_z = vel[2];
    pt.acc_x = acc[0];
    pt.acc_y = acc[1];
    pt.acc_z = acc[2];
    pt.finished = done;
    return pt;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    traj_point_t want;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        profile_regs[cfg_bus.addr] = cfg_bus.data;
      end
      if (in_bus.valid && in_bus.ready) begin
        expected_points.push_back(predict_point(in_bus.sample_time));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: trajectory point with none expected", $time);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("pos_x", want.pos_x, out_bus.pos_x);
          check_field("pos_y", want.pos_y, out_bus.pos_y);
          check_field("pos_z", want.pos_z, out_bus.pos_z);
          check_field("vel_x", want.vel_x, out_bus.vel_x);
          check_field("vel_y", want.vel_y, out_bus.vel_y);
          check_field("vel_z", want.vel_z, out_bus.vel_z);
          check_field("acc_x", want.acc_x, out_bus.acc_x);
          check_field("acc_y", want.acc_y, out_bus.acc_y);
          check_field("acc_z", want.acc_z, out_bus.acc_z);
          check_field("finished", {31'b0, want.finished}, {31'b0, out_bus.finished});
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_min_jerk_trajectory_eval_unit failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // The receiver switches between stall patterns and honors a long hold-off on request.
  initial begin : receiver
    rx_mode_t rx_mode;
    int rx_phase_left;
    int rx_hold_left;
    rx_mode = RX_FREE;
    rx_phase_left = 0;
    rx_hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_hold_left = HOLD_OFF_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          rx_phase_left = $urandom_range(10, 80);
        end
        rx_phase_left--;
        case (rx_mode)
          RX_FREE: begin
            out_bus.ready <= 1'b1;
          end
          RX_COIN: begin
            out_bus.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_bus.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  task automatic send_sample(logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid <= 1'b1;
    in_bus.sample_time <= t;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_profile(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                 logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                 logic [31:0] rate, logic [31:0] rate_sq);
    int i;
    profile_plan[REG_START_X] = sx;
    profile_plan[REG_START_Y] = sy;
    profile_plan[REG_START_Z] = sz;
    profile_plan[REG_DELTA_X] = dx;
    profile_plan[REG_DELTA_Y] = dy;
    profile_plan[REG_DELTA_Z] = dz;
    profile_plan[REG_INV_DUR] = rate;
    profile_plan[REG_INV_DUR_SQ] = rate_sq;
    for (i = 0; i < NUM_REGS; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.addr <= cfg_reg_t'(i);
      cfg_bus.data <= profile_plan[i];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0000;
      default: return $urandom_range(32'h0000_2000, 32'h0008_0000);
    endcase
  endfunction

  // Most samples fall within about one and a quarter trajectory durations.
  function automatic logic [31:0] pick_time();
    logic [63:0] span;
    if ($urandom_range(0, 9) == 0 || profile_plan[REG_INV_DUR] == 32'h0) return $urandom();
    span = 64'h1_4000_0000 / profile_plan[REG_INV_DUR];
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return $urandom_range(0, span[31:0]);
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'h0000_0000);
    send_sample(32'h0000_8000);
    send_sample(32'h0002_0000);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    program_profile(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0001_0000, 32'h0001_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_4000);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_FFFF);
    send_sample(32'h0001_0000);
    send_sample(32'h0001_0001);
    send_sample(32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_end_boundary();
    program_profile(32'hFFFF_0000, 32'h0000_8000, 32'h0123_4567,
                    32'h0002_0000, 32'hFFFC_0000, 32'h0000_0001,
                    32'h0002_0000, 32'h0004_0000);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_8001);
    wait_drained();
    program_profile(32'hFFFF_0000, 32'h0000_8000, 32'h0123_4567,
                    32'h0002_0000, 32'hFFFC_0000, 32'h0000_0001,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0002);
    wait_drained();
  endtask

  task automatic test_zero_rate();
    program_profile(32'h1234_5678, 32'h8765_4321, 32'h0000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000,
                    32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h1234_5678);
    wait_drained();
  endtask

  task automatic test_saturation();
    program_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                    32'h0100_0000, 32'hFFFF_FFFF);
    send_sample(32'h0000_0080);
    send_sample(32'h0000_0020);
    wait_drained();
  endtask

  task automatic test_random_profiles();
    logic [31:0] rate, rate_sq;
    logic [63:0] sq;
    int p, n;
    for (p = 0; p < RANDOM_PROFILES; p++) begin
      rate = pick_rate();
      sq = (64'(rate) * 64'(rate)) >> FRAC;
      if ($urandom_range(0, 1) == 0) begin
        rate_sq = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
      end else begin
        rate_sq = pick_rate();
      end
      program_profile(pick_offset(), pick_offset(), pick_offset(),
                      pick_offset(), pick_offset(), pick_offset(), rate, rate_sq);
      for (n = 0; n < SAMPLES_PER_PROFILE; n++) begin
        send_sample(pick_time());
      end
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    int n;
    program_profile(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
                    32'h0020_0000, 32'hFFE0_0000, 32'h0001_0000,
                    32'h0000_8000, 32'h0000_4000);
    hold_off_req = 1'b1;
    for (n = 0; n < 80; n++) begin
      send_sample(pick_time());
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample_time = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr = '0;
    cfg_bus.data = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      profile_regs[i] = '0;
      profile_plan[i] = '0;
    end
    profile_regs[REG_INV_DUR] = ONE_Q16;
    profile_regs[REG_INV_DUR_SQ] = ONE_Q16;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_end_boundary();
    test_zero_rate();
    test_saturation();
    test_random_profiles();
    test_backpressure();
    if (error_count == 0) begin
      $display("tb_min_jerk_trajectory_eval_unit passed");
    end else begin
      $display("tb_min_jerk_trajectory_eval_unit failed");
    end
    $finish;
  end

endmodule
